// ===== hdl/bft_pkg.sv =====
// ----------------------------------------------------------------------------
// bft_pkg: shared types and constants of the bidirectional flow block
// Payload structs, stored record layouts and ranked-list command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bft_pkg;

  localparam int FLOW_ENTRIES_DEF = 1024;
  localparam int TOP_N_DEF        = 10;

  typedef struct packed {
    logic        op;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic        is_ipv6;
    logic [31:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_src_hi;
    logic [63:0] out_src_lo;
    logic [63:0] out_dst_hi;
    logic [63:0] out_dst_lo;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [8:0]  out_proto_ver;
    logic [63:0] rx_byte_total;
    logic [63:0] tx_byte_total;
    logic [31:0] rx_packet_total;
    logic [31:0] tx_packet_total;
    logic        last;
  } out_item_t;

  // Stored flow key.
  typedef struct packed {
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic        is_ipv6;
    logic [7:0]  protocol;
    logic [15:0] dport;
    logic [15:0] sport;
  } key_t;

  // Stored counters of one flow.
  typedef struct packed {
    logic [63:0] rx_octets;
    logic [63:0] tx_octets;
    logic [31:0] rx_pkts;
    logic [31:0] tx_pkts;
  } cnt_t;

  localparam int KEY_W = $bits(key_t);
  localparam int CNT_W = $bits(cnt_t);

  // Ranked list commands.
  localparam logic [2:0] RK_NOP    = 3'd0;
  localparam logic [2:0] RK_TOUCH  = 3'd1;
  localparam logic [2:0] RK_LOAD   = 3'd2;
  localparam logic [2:0] RK_CMP    = 3'd3;
  localparam logic [2:0] RK_FLUSH  = 3'd4;
  localparam logic [2:0] RK_DROP   = 3'd5;
  localparam logic [2:0] RK_CLEAR  = 3'd6;
  localparam logic [2:0] RK_ROTATE = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic       by_pkts;
  } rank_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/bft_ram.sv =====
// ----------------------------------------------------------------------------
// bft_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bft_rank.sv =====
// ----------------------------------------------------------------------------
// bft_rank: ranked talker list
// A ring of TOP_N+1 entries sorted by bubble passes through one comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_rank
  import bft_pkg::*;
#(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
  parameter int TOP_N        = TOP_N_DEF,
  localparam int AW = $clog2(FLOW_ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rank_ctl_t       ctl,
  input  wire logic [AW-1:0]   touch_slot,
  input  wire logic [63:0]     touch_bmax,
  input  wire logic [31:0]     touch_pmax,
  output logic                 head_vld,
  output logic      [AW-1:0]   head_slot
);

  localparam int M = TOP_N + 1;

  typedef struct packed {
    logic          vld;
    logic [AW-1:0] slot;
    logic [63:0]   bmax;
    logic [31:0]   pmax;
  } ent_t;

  ent_t ring_r [M];
  ent_t ring_nxt [M];
  ent_t carry_r, carry_nxt;
  logic [M-1:0] hit;
  logic         gt;

  function automatic logic [63:0] key_of(input ent_t e, input logic by_pkts);
    return by_pkts ? {32'd0, e.pmax} : e.bmax;
  endfunction

  // Invalid entries rank below every valid one.
  assign gt = carry_r.vld &&
              (!ring_r[0].vld ||
               key_of(carry_r, ctl.by_pkts) > key_of(ring_r[0], ctl.by_pkts));

  always_comb begin
    for (int i = 0; i < M; i++) begin
      hit[i] = ring_r[i].vld && (ring_r[i].slot == touch_slot);
    end
  end

  always_comb begin
    for (int i = 0; i < M; i++) begin
      ring_nxt[i] = ring_r[i];
    end
    carry_nxt = carry_r;
    unique case (ctl.cmd)
      RK_TOUCH: begin
        for (int i = 0; i < M; i++) begin
          if (hit[i]) begin
            ring_nxt[i].bmax = touch_bmax;
            ring_nxt[i].pmax = touch_pmax;
          end
        end
        // The front slot is always free here, ahead of every valid entry.
        if (hit == '0) begin
          ring_nxt[0] = '{vld: 1'b1, slot: touch_slot, bmax: touch_bmax, pmax: touch_pmax};
        end
      end
      RK_LOAD, RK_ROTATE: begin
        if (ctl.cmd == RK_LOAD) begin
          carry_nxt = ring_r[0];
        end
        for (int i = 0; i < M - 1; i++) begin
          ring_nxt[i] = ring_r[i+1];
        end
        ring_nxt[M-1] = ring_r[0];
      end
      RK_CMP: begin
        for (int i = 0; i < M - 1; i++) begin
          ring_nxt[i] = ring_r[i+1];
        end
        ring_nxt[M-1] = gt ? ring_r[0] : carry_r;
        carry_nxt     = gt ? carry_r : ring_r[0];
      end
      RK_FLUSH: begin
        for (int i = 0; i < M - 1; i++) begin
          ring_nxt[i] = ring_r[i+1];
        end
        ring_nxt[M-1] = carry_r;
      end
      RK_DROP: begin
        if (ring_r[0].vld && ring_r[M-1].vld) begin
          ring_nxt[0].vld = 1'b0;
        end
      end
      RK_CLEAR: begin
        for (int i = 0; i < M; i++) begin
          ring_nxt[i].vld = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < M; i++) begin
      ring_r[i].slot <= ring_nxt[i].slot;
      ring_r[i].bmax <= ring_nxt[i].bmax;
      ring_r[i].pmax <= ring_nxt[i].pmax;
      if (!rst_n) begin
        ring_r[i].vld <= 1'b0;
      end else begin
        ring_r[i].vld <= ring_nxt[i].vld;
      end
    end
    carry_r <= carry_nxt;
  end

  assign head_vld  = ring_r[0].vld;
  assign head_slot = ring_r[0].slot;

endmodule

`default_nettype wire

// ===== hdl/bidirectional_flow_top_ten.sv =====
// ----------------------------------------------------------------------------
// bidirectional_flow_top_ten: flow table with a ranked ten-entry talker list
// An accounted packet keeps busy high for at most a table scan of one entry per cycle
// plus TOP_N bubble passes over the ranked list.
// A report sends one result per ranked flow, then empties the table and the list; one item at a time.
// Results come one per strobe cycle and cannot be stalled. Synchronous active-low
// reset empties the table and the ranked list at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_flow_top_ten
  import bft_pkg::*;
#(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF,
  parameter int TOP_N        = TOP_N_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_strobe,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int AW = $clog2(FLOW_ENTRIES);
  localparam int FW = $clog2(FLOW_ENTRIES + 1);
  localparam int M  = TOP_N + 1;
  localparam int SW = $clog2(M + 1);
  localparam int PW = $clog2(M);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_CNT_RD = 4'd2;
  localparam logic [3:0] ST_CNT_UP = 4'd3;
  localparam logic [3:0] ST_INSERT = 4'd4;
  localparam logic [3:0] ST_RANK   = 4'd5;
  localparam logic [3:0] ST_SORT   = 4'd6;
  localparam logic [3:0] ST_DROP   = 4'd7;
  localparam logic [3:0] ST_REP_RD = 4'd8;
  localparam logic [3:0] ST_REP_OUT = 4'd9;

  logic [3:0]    state_r, state_nxt;
  in_item_t      item_r;
  logic          by_pkts_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          rev_hit_r, rev_hit_nxt;
  logic [AW-1:0] rev_idx_r, rev_idx_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic          dir_tx_r, dir_tx_nxt;
  cnt_t          cnt_r, cnt_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic          out_strobe_nxt;

  key_t          key_fwd, key_rev, key_q;
  logic [KEY_W-1:0] key_rd_data;
  logic          key_rd_en, key_wr_en;
  logic [AW-1:0] key_rd_addr;
  cnt_t          cnt_q, cnt_wr_data;
  logic [CNT_W-1:0] cnt_rd_data;
  logic          cnt_rd_en, cnt_wr_en;
  logic [AW-1:0] cnt_rd_addr;

  rank_ctl_t     rk_ctl;
  logic          head_vld;
  logic [AW-1:0] head_slot;
  logic [63:0]   bmax;
  logic [31:0]   pmax;

  logic          issue;
  logic [64:0]   bsum;
  logic [63:0]   bnew;
  logic [31:0]   pold, pnew;

  assign key_fwd = '{src_hi: item_r.src_addr_hi, src_lo: item_r.src_addr_lo,
                     dst_hi: item_r.dst_addr_hi, dst_lo: item_r.dst_addr_lo,
                     is_ipv6: item_r.is_ipv6, protocol: item_r.protocol,
                     dport: item_r.dport, sport: item_r.sport};
  assign key_rev = '{src_hi: item_r.dst_addr_hi, src_lo: item_r.dst_addr_lo,
                     dst_hi: item_r.src_addr_hi, dst_lo: item_r.src_addr_lo,
                     is_ipv6: item_r.is_ipv6, protocol: item_r.protocol,
                     dport: item_r.sport, sport: item_r.dport};
  assign key_q = key_t'(key_rd_data);
  assign cnt_q = cnt_t'(cnt_rd_data);

  bft_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (key_fwd),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  bft_ram #(.WIDTH(CNT_W), .DEPTH(FLOW_ENTRIES)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (hit_idx_nxt),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  bft_rank #(.FLOW_ENTRIES(FLOW_ENTRIES), .TOP_N(TOP_N)) u_rank (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (rk_ctl),
    .touch_slot (hit_idx_r),
    .touch_bmax (bmax),
    .touch_pmax (pmax),
    .head_vld   (head_vld),
    .head_slot  (head_slot)
  );

  // Saturating update of the counters on the side the packet hit.
  always_comb begin
    bsum = {1'b0, (dir_tx_r ? cnt_q.tx_octets : cnt_q.rx_octets)} +
           {33'd0, item_r.byte_count};
    bnew = bsum[64] ? '1 : bsum[63:0];
    pold = dir_tx_r ? cnt_q.tx_pkts : cnt_q.rx_pkts;
    pnew = (pold == '1) ? pold : pold + 32'd1;
  end

  assign bmax = (cnt_r.rx_octets > cnt_r.tx_octets) ? cnt_r.rx_octets : cnt_r.tx_octets;
  assign pmax = (cnt_r.rx_pkts > cnt_r.tx_pkts) ? cnt_r.rx_pkts : cnt_r.tx_pkts;
  assign issue = idx_r < fill_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    rev_hit_nxt    = rev_hit_r;
    rev_idx_nxt    = rev_idx_r;
    hit_idx_nxt    = hit_idx_r;
    dir_tx_nxt     = dir_tx_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    pass_nxt       = pass_r;
    out_strobe_nxt = 1'b0;
    key_rd_en      = 1'b0;
    key_rd_addr    = idx_r[AW-1:0];
    key_wr_en      = 1'b0;
    cnt_rd_en      = 1'b0;
    cnt_rd_addr    = hit_idx_r;
    cnt_wr_en      = 1'b0;
    cnt_wr_data    = cnt_r;
    rk_ctl.cmd     = RK_NOP;
    rk_ctl.by_pkts = by_pkts_r;

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt     = '0;
        rev_hit_nxt = 1'b0;
        step_nxt    = '0;
        if (start) begin
          state_nxt = in_item.op ? ST_REP_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // One table entry is read per cycle; its key is checked in the following cycle.
        key_rd_en = issue;
        pend_nxt  = issue;
        pidx_nxt  = idx_r[AW-1:0];
        if (issue) begin
          idx_nxt = idx_r + FW'(1);
        end
        if (pend_r && key_q == key_fwd) begin
          hit_idx_nxt = pidx_r;
          dir_tx_nxt  = 1'b1;
          state_nxt   = ST_CNT_RD;
        end else begin
          if (pend_r && key_q == key_rev && !rev_hit_r) begin
            rev_hit_nxt = 1'b1;
            rev_idx_nxt = pidx_r;
          end
          if (!issue && !pend_r) begin
            priority if (rev_hit_r) begin
              hit_idx_nxt = rev_idx_r;
              dir_tx_nxt  = 1'b0;
              state_nxt   = ST_CNT_RD;
            end else if (fill_r == FW'(FLOW_ENTRIES)) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_INSERT;
            end
          end
        end
      end
      ST_CNT_RD: begin
        cnt_rd_en = 1'b1;
        state_nxt = ST_CNT_UP;
      end
      ST_CNT_UP: begin
        cnt_nxt = cnt_q;
        if (dir_tx_r) begin
          cnt_nxt.tx_octets = bnew;
          cnt_nxt.tx_pkts   = pnew;
        end else begin
          cnt_nxt.rx_octets = bnew;
          cnt_nxt.rx_pkts   = pnew;
        end
        cnt_wr_en   = 1'b1;
        cnt_wr_data = cnt_nxt;
        state_nxt   = ST_RANK;
      end
      ST_INSERT: begin
        cnt_nxt     = '{rx_octets: 64'd0, tx_octets: {32'd0, item_r.byte_count},
                        rx_pkts: 32'd0, tx_pkts: 32'd1};
        hit_idx_nxt = fill_r[AW-1:0];
        key_wr_en   = 1'b1;
        cnt_wr_en   = 1'b1;
        cnt_wr_data = cnt_nxt;
        fill_nxt    = fill_r + FW'(1);
        state_nxt   = ST_RANK;
      end
      ST_RANK: begin
        rk_ctl.cmd = RK_TOUCH;
        step_nxt   = '0;
        pass_nxt   = '0;
        state_nxt  = ST_SORT;
      end
      ST_SORT: begin
        // Each pass: load the carry, compare against every other entry, flush it.
        priority if (step_r == '0) begin
          rk_ctl.cmd = RK_LOAD;
        end else if (step_r == SW'(M)) begin
          rk_ctl.cmd = RK_FLUSH;
        end else begin
          rk_ctl.cmd = RK_CMP;
        end
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(M)) begin
          step_nxt = '0;
          pass_nxt = pass_r + PW'(1);
          if (pass_r == PW'(M - 2)) begin
            state_nxt = ST_DROP;
          end
        end
      end
      ST_DROP: begin
        rk_ctl.cmd = RK_DROP;
        state_nxt  = ST_IDLE;
      end
      ST_REP_RD: begin
        key_rd_addr = head_slot;
        cnt_rd_addr = head_slot;
        priority if (step_r == SW'(M)) begin
          rk_ctl.cmd = RK_CLEAR;
          fill_nxt   = '0;
          state_nxt  = ST_IDLE;
        end else if (head_vld) begin
          key_rd_en = 1'b1;
          cnt_rd_en = 1'b1;
          state_nxt = ST_REP_OUT;
        end else begin
          rk_ctl.cmd = RK_ROTATE;
          step_nxt   = step_r + SW'(1);
        end
      end
      ST_REP_OUT: begin
        out_strobe_nxt = 1'b1;
        rk_ctl.cmd     = RK_ROTATE;
        step_nxt       = step_r + SW'(1);
        state_nxt      = ST_REP_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      by_pkts_r  <= 1'b0;
      pend_r     <= 1'b0;
      rev_hit_r  <= 1'b0;
      out_strobe <= 1'b0;
      step_r     <= '0;
      pass_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      pend_r     <= pend_nxt;
      rev_hit_r  <= rev_hit_nxt;
      out_strobe <= out_strobe_nxt;
      step_r     <= step_nxt;
      pass_r     <= pass_nxt;
      if (cfg_we) begin
        by_pkts_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      item_r <= in_item;
    end
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    rev_idx_r <= rev_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    dir_tx_r  <= dir_tx_nxt;
    cnt_r     <= cnt_nxt;
    if (out_strobe_nxt) begin
      out_item.out_src_hi      <= key_q.src_hi;
      out_item.out_src_lo      <= key_q.src_lo;
      out_item.out_dst_hi      <= key_q.dst_hi;
      out_item.out_dst_lo      <= key_q.dst_lo;
      out_item.out_src_port    <= key_q.sport;
      out_item.out_dst_port    <= key_q.dport;
      out_item.out_proto_ver   <= {key_q.is_ipv6, key_q.protocol};
      out_item.rx_byte_total   <= cnt_q.rx_octets;
      out_item.tx_byte_total   <= cnt_q.tx_octets;
      out_item.rx_packet_total <= cnt_q.rx_pkts;
      out_item.tx_packet_total <= cnt_q.tx_pkts;
      out_item.last            <= (step_r == SW'(M - 1));
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire
